// File: rtl/core/mca_pkg.sv
// Shared types and constants for the marker corner angle block.
// Holds item, result and work-queue types plus the CORDIC angle table.
// No dependencies.
`default_nettype none

package mca_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int CORDIC_STAGES   = 16;

  localparam int ANGLE_W   = 15;
  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int ACC_FRAC  = 24;
  localparam int XY_FRAC   = ACC_FRAC;
  localparam int XY_W      = COORD_WIDTH + 4 + XY_FRAC;
  localparam int ACC_W     = ACC_FRAC + 11;
  localparam int Q_W       = ANGLE_FRAC_BITS + 9;
  localparam int TAB_LEN   = 24;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CORNER0 = 2'd0;
  localparam logic [1:0] CORNER1 = 2'd1;
  localparam logic [1:0] CORNER2 = 2'd2;
  localparam logic [1:0] CORNER3 = 2'd3;

  localparam logic signed [ACC_W-1:0] ACC_180 = ACC_W'(64'd180 << ACC_FRAC);
  localparam logic signed [ACC_W-1:0] ACC_360 = ACC_W'(64'd360 << ACC_FRAC);
  localparam logic signed [ACC_W-1:0] ACC_HALF =
    ACC_W'(64'd1 << (ACC_FRAC - 1 - ANGLE_FRAC_BITS));
  localparam logic [Q_W-1:0] Q_FULL = Q_W'(64'd360 << ANGLE_FRAC_BITS);

  // atan(2^-i) in degrees, scaled by 2^24
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  typedef struct packed {
    logic [1:0]                    corner_select;
    logic signed [COORD_WIDTH-1:0] corner0_x;
    logic signed [COORD_WIDTH-1:0] corner0_y;
    logic signed [COORD_WIDTH-1:0] corner1_x;
    logic signed [COORD_WIDTH-1:0] corner1_y;
    logic signed [COORD_WIDTH-1:0] corner2_x;
    logic signed [COORD_WIDTH-1:0] corner2_y;
    logic signed [COORD_WIDTH-1:0] corner3_x;
    logic signed [COORD_WIDTH-1:0] corner3_y;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
  } mca_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic               zero_vector;
  } mca_result_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
  } mca_work_t;

endpackage

`default_nettype wire

// File: rtl/core/mca_front.sv
// Front end: accepts items, picks the marked corner, forms the folded vector.
// Depends on mca_pkg.
`default_nettype none

module mca_front
  import mca_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire mca_item_t item_i,
  output logic           busy,
  input  wire logic      full_i,
  output logic           push_o,
  output mca_work_t      work_o
);

  logic                    valid_q, valid_d;
  logic                    accept;
  mca_work_t               work_q, work_d;
  logic signed [COORD_WIDTH-1:0] px, py;
  logic signed [DIFF_W-1:0] dx, up;
  logic signed [DIFF_W:0]   fx, fy;
  logic                     neg;

  assign busy   = valid_q & full_i;
  assign accept = start & ~busy;
  assign push_o = valid_q & ~full_i;
  assign work_o = work_q;
  assign valid_d = accept | (valid_q & full_i);

  always_comb begin
    case (item_i.corner_select)
      CORNER0: begin px = item_i.corner0_x; py = item_i.corner0_y; end
      CORNER1: begin px = item_i.corner1_x; py = item_i.corner1_y; end
      CORNER2: begin px = item_i.corner2_x; py = item_i.corner2_y; end
      CORNER3: begin px = item_i.corner3_x; py = item_i.corner3_y; end
      default: begin px = item_i.corner0_x; py = item_i.corner0_y; end
    endcase
  end

  always_comb begin
    dx  = DIFF_W'(px) - DIFF_W'(item_i.center_x);
    up  = DIFF_W'(item_i.center_y) - DIFF_W'(py);
    neg = dx[DIFF_W-1];
    fx  = neg ? -(DIFF_W + 1)'(dx) : (DIFF_W + 1)'(dx);
    fy  = neg ? -(DIFF_W + 1)'(up) : (DIFF_W + 1)'(up);
    work_d.x    = {(XY_W - XY_FRAC)'(fx), {XY_FRAC{1'b0}}};
    work_d.y    = {(XY_W - XY_FRAC)'(fy), {XY_FRAC{1'b0}}};
    work_d.acc  = neg ? ACC_180 : '0;
    work_d.zero = (dx == '0) && (up == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_q <= work_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mca_queue.sv
// Short work queue between front end and CORDIC back end.
// Depends on mca_pkg.
`default_nettype none

module mca_queue
  import mca_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire mca_work_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output mca_work_t      data_o,
  output logic           empty_o
);

  mca_work_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mca_cordic.sv
// Back end: pipelined vectoring CORDIC, one stage per iteration, then
// fold into [0,360), round to the output step and wrap. Depends on mca_pkg.
`default_nettype none

module mca_cordic
  import mca_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire mca_work_t work_i,
  output logic           done_o,
  output mca_result_t    result_o
);

  logic signed [XY_W-1:0]  x_q   [CORDIC_STAGES+1];
  logic signed [XY_W-1:0]  y_q   [CORDIC_STAGES+1];
  logic signed [ACC_W-1:0] acc_q [CORDIC_STAGES+1];
  logic                    zero_q [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0]  valid_q;

  logic signed [ACC_W-1:0] pos_q, pos_d;
  logic [Q_W-1:0]          raw_q, raw_d;
  logic [ACC_W-1:0]        rsum;
  logic [Q_W-1:0]          wrap_d;
  logic [2:0]              tail_valid_q;
  logic [1:0]              tail_zero_q;
  mca_result_t             result_q;

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      x_q[0]    <= work_i.x;
      y_q[0]    <= work_i.y;
      acc_q[0]  <= work_i.acc;
      zero_q[0] <= work_i.zero;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0]  xs, ys;
    logic signed [ACC_W-1:0] ang;
    assign xs  = x_q[i] >>> i;
    assign ys  = y_q[i] >>> i;
    assign ang = $signed(ACC_W'(ATAN_TAB[i]));

    always_ff @(posedge clk_i) begin
      if (!y_q[i][XY_W-1]) begin
        x_q[i+1]   <= x_q[i] + ys;
        y_q[i+1]   <= y_q[i] - xs;
        acc_q[i+1] <= acc_q[i] + ang;
      end else begin
        x_q[i+1]   <= x_q[i] - ys;
        y_q[i+1]   <= y_q[i] + xs;
        acc_q[i+1] <= acc_q[i] - ang;
      end
      zero_q[i+1] <= zero_q[i];
    end
  end

  always_comb begin
    pos_d  = acc_q[CORDIC_STAGES][ACC_W-1] ? acc_q[CORDIC_STAGES] + ACC_360
                                           : acc_q[CORDIC_STAGES];
    rsum   = pos_q + ACC_HALF;
    raw_d  = rsum[ACC_FRAC - ANGLE_FRAC_BITS +: Q_W];
    wrap_d = (raw_q >= Q_FULL) ? raw_q - Q_FULL : raw_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      tail_valid_q <= '0;
    end else begin
      valid_q      <= {valid_q[CORDIC_STAGES-1:0], valid_i};
      tail_valid_q <= {tail_valid_q[1:0], valid_q[CORDIC_STAGES]};
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q          <= pos_d;
    raw_q          <= raw_d;
    tail_zero_q    <= {tail_zero_q[0], zero_q[CORDIC_STAGES]};
    result_q.zero_vector <= tail_zero_q[1];
    result_q.angle_deg   <= tail_zero_q[1] ? '0 : ANGLE_W'(wrap_d);
  end

  assign done_o   = tail_valid_q[2];
  assign result_o = result_q;

endmodule

`default_nettype wire

// File: rtl/core/marker_corner_angle.sv
// Top level of the marker corner angle block: front end, work queue, CORDIC.
// Depends on mca_pkg, mca_front, mca_queue, mca_cordic.
//
//   channel  handshake             payload
//   item     start in, busy out    item_i   (mca_item_t)
//   result   done_o out            result_o (mca_result_t)
//
// One item per cycle is taken while busy is low; after its item is accepted, a
// result passes through the front register, a queue entry, the CORDIC input and
// stage registers, then the fold, rounding and result registers.
// Reset clears only valid and pointer state; payload registers float.
// Results cannot be held off, so the back end never stalls and busy stays low
// in practice; busy rises only if the queue is full with the front loaded.
`default_nettype none

module marker_corner_angle
  import mca_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire mca_item_t item_i,
  output logic           busy,
  output logic           done_o,
  output mca_result_t    result_o
);

  logic      push, full, empty;
  mca_work_t front_work, back_work;

  mca_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .item_i (item_i),
    .busy   (busy),
    .full_i (full),
    .push_o (push),
    .work_o (front_work)
  );

  mca_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_work),
    .full_o  (full),
    .pop_i   (~empty),
    .data_o  (back_work),
    .empty_o (empty)
  );

  mca_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (~empty),
    .work_i   (back_work),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
